[rtl/stmig_pkg.sv]
// shared types, constants and helpers for the structured triangle mesh index generator
package stmig_pkg;

  localparam int IDX_W   = 21;
  localparam int VTX_W   = 20;
  localparam int CRD_W   = 26;
  localparam int SIDE_W  = 3;
  localparam int DIM_W   = 11;
  localparam int SPC_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 2;
  localparam int TOFF_W  = 10;
  localparam int MAX_SIDE = 1024;

  // operation codes
  localparam logic [1:0] OP_VERTEX   = 2'd0;
  localparam logic [1:0] OP_TRIANGLE = 2'd1;
  localparam logic [1:0] OP_EDGE     = 2'd2;

  // register indexes
  localparam logic [CIDX_W-1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SPACING   = 2'd2;

  // boundary side numbers
  localparam logic [SIDE_W-1:0] SIDE_NONE   = 3'd0;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 3'd1;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 3'd2;
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 3'd3;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 3'd4;

  typedef struct packed {
    logic [1:0]       operation;
    logic [IDX_W-1:0] entry_index;
  } query_t;

  typedef struct packed {
    logic [VTX_W-1:0]  first_vertex;
    logic [VTX_W-1:0]  second_vertex;
    logic [VTX_W-1:0]  third_vertex;
    logic [CRD_W-1:0]  coord_one;
    logic [CRD_W-1:0]  coord_two;
    logic [SIDE_W-1:0] side_number;
    logic              status;
  } result_t;

  // grid geometry, to be kept static by the user while items are in flight; the block does not enforce this
  typedef struct packed {
    logic [DIM_W-1:0] m1;
    logic [DIM_W-1:0] m2;
    logic [SPC_W-1:0] spacing;
    logic [IDX_W-1:0] nv;
    logic [IDX_W-1:0] ntri;
    logic [IDX_W-1:0] top_base;
    logic [IDX_W-1:0] left_base;
  } geom_t;

  // per-item sideband that rides along the divider
  typedef struct packed {
    logic [1:0]        op;
    logic              bad;
    logic [SIDE_W-1:0] side;
    logic              parity;
    logic [VTX_W-1:0]  half;
    logic [VTX_W-1:0]  base;
    logic [TOFF_W-1:0] toff;
    logic              neg;
    logic [DIM_W-1:0]  delta;
    logic              dec;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_side(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v < DIM_W'(2)) r = DIM_W'(2);
    else if (v > DIM_W'(MAX_SIDE)) r = DIM_W'(MAX_SIDE);
    else r = v;
    return r;
  endfunction

endpackage

[rtl/stmig_decode.sv]
// input register and query decode stage
module stmig_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                req_valid,
  input  stmig_pkg::query_t                   req,
  input  stmig_pkg::geom_t                    geom,
  output logic                                dec_valid,
  output logic [stmig_pkg::IDX_W-1:0]         num,
  output logic [stmig_pkg::DIM_W-1:0]         den,
  output stmig_pkg::item_t                    item
);

  logic              s1_valid;
  stmig_pkg::query_t s1;

  logic [stmig_pkg::IDX_W-1:0] idx;
  logic [12:0]                 e1, e2, e3, e4;
  logic [stmig_pkg::IDX_W-1:0] num_next;
  logic [stmig_pkg::DIM_W-1:0] den_next;
  stmig_pkg::item_t            item_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      dec_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= req_valid;
      dec_valid <= s1_valid;
    end
    if (adv) begin
      s1   <= req;
      num  <= num_next;
      den  <= den_next;
      item <= item_next;
    end
  end

  // segment limits of the boundary walk
  assign idx = s1.entry_index;
  assign e1  = 13'(geom.m1) - 13'd1;
  assign e2  = 13'(geom.m1) + 13'(geom.m2) - 13'd2;
  assign e3  = e2 + 13'(geom.m1) - 13'd1;
  assign e4  = {e2[11:0], 1'b0};

  always_comb begin
    item_next        = '0;
    item_next.op     = s1.operation;
    item_next.half   = idx[stmig_pkg::IDX_W-1:1];
    item_next.parity = idx[0];
    num_next         = idx;
    den_next         = geom.m1;
    unique case (s1.operation)
      stmig_pkg::OP_VERTEX: begin
        item_next.bad = (idx >= geom.nv);
      end
      stmig_pkg::OP_TRIANGLE: begin
        item_next.bad = (idx >= geom.ntri);
        num_next      = {1'b0, idx[stmig_pkg::IDX_W-1:1]};
        den_next      = geom.m1 - stmig_pkg::DIM_W'(1);
      end
      stmig_pkg::OP_EDGE: begin
        priority if (idx < 21'(e1)) begin
          item_next.side  = stmig_pkg::SIDE_BOTTOM;
          item_next.base  = idx[stmig_pkg::VTX_W-1:0];
          item_next.delta = stmig_pkg::DIM_W'(1);
        end else if (idx < 21'(e2)) begin
          item_next.side  = stmig_pkg::SIDE_RIGHT;
          item_next.base  = 20'(e1);
          item_next.toff  = 10'(idx - 21'(e1));
          item_next.delta = geom.m1;
        end else if (idx < 21'(e3)) begin
          item_next.side  = stmig_pkg::SIDE_TOP;
          item_next.base  = 20'(geom.top_base - idx);
          item_next.delta = stmig_pkg::DIM_W'(1);
          item_next.dec   = 1'b1;
        end else if (idx < 21'(e4)) begin
          item_next.side  = stmig_pkg::SIDE_LEFT;
          item_next.base  = 20'(geom.left_base);
          item_next.toff  = 10'(idx - 21'(e3));
          item_next.neg   = 1'b1;
          item_next.delta = geom.m1;
          item_next.dec   = 1'b1;
        end else begin
          item_next.bad   = 1'b1;
        end
      end
      default: begin
        item_next.bad = 1'b1;
      end
    endcase
  end

endmodule

[rtl/stmig_divider.sv]
// pipelined restoring divider, one quotient bit per stage, sideband carried along
module stmig_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [stmig_pkg::IDX_W-1:0] num,
  input  logic [stmig_pkg::DIM_W-1:0] den,
  input  stmig_pkg::item_t            in_item,
  output logic                        out_valid,
  output logic [stmig_pkg::IDX_W-1:0] quo,
  output logic [stmig_pkg::DIM_W-1:0] rem,
  output stmig_pkg::item_t            out_item
);

  localparam int N = stmig_pkg::IDX_W;
  localparam int R = stmig_pkg::DIM_W;

  logic [N-1:0]     vld;
  logic [N-1:0]     num_q  [N];
  logic [N-1:0]     quo_q  [N];
  logic [R-1:0]     rem_q  [N];
  logic [R-1:0]     den_q  [N];
  stmig_pkg::item_t item_q [N];

  logic [N-1:0]     vld_next;
  logic [N-1:0]     num_next  [N];
  logic [N-1:0]     quo_next  [N];
  logic [R-1:0]     rem_next  [N];
  logic [R-1:0]     den_next  [N];
  stmig_pkg::item_t item_next [N];

  always_comb begin
    logic [N-1:0]     n_in;
    logic [N-1:0]     q_in;
    logic [R-1:0]     r_in;
    logic [R-1:0]     d_in;
    logic [R:0]       trial;
    logic             ge;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        n_in         = num;
        q_in         = '0;
        r_in         = '0;
        d_in         = den;
        vld_next[k]  = in_valid;
        item_next[k] = in_item;
      end else begin
        n_in         = num_q[k-1];
        q_in         = quo_q[k-1];
        r_in         = rem_q[k-1];
        d_in         = den_q[k-1];
        vld_next[k]  = vld[k-1];
        item_next[k] = item_q[k-1];
      end
      trial       = {r_in, n_in[N-1]};
      ge          = (trial >= {1'b0, d_in});
      rem_next[k] = ge ? R'(trial - {1'b0, d_in}) : trial[R-1:0];
      quo_next[k] = {q_in[N-2:0], ge};
      num_next[k] = {n_in[N-2:0], 1'b0};
      den_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= vld_next;
    end
    if (adv) begin
      for (int k = 0; k < N; k++) begin
        num_q[k]  <= num_next[k];
        quo_q[k]  <= quo_next[k];
        rem_q[k]  <= rem_next[k];
        den_q[k]  <= den_next[k];
        item_q[k] <= item_next[k];
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quo       = quo_q[N-1];
  assign rem       = rem_q[N-1];
  assign out_item  = item_q[N-1];

endmodule

[rtl/stmig_finish.sv]
// back end: coordinate products, vertex sums and the result register
module stmig_finish (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [stmig_pkg::IDX_W-1:0] quo,
  input  logic [stmig_pkg::DIM_W-1:0] rem,
  input  stmig_pkg::item_t            item,
  input  stmig_pkg::geom_t            geom,
  output logic                        rsp_valid,
  output stmig_pkg::result_t          rsp
);

  localparam int V = stmig_pkg::VTX_W;
  localparam int C = stmig_pkg::CRD_W;

  // stage one
  logic             f1_valid;
  stmig_pkg::item_t f1_item;
  logic [C-1:0]     f1_x1, f1_x2;
  logic [V-1:0]     f1_ta, f1_p;

  // stage two
  logic             f2_valid;
  stmig_pkg::item_t f2_item;
  logic [C-1:0]     f2_x1, f2_x2;
  logic [V-1:0]     f2_ta, f2_tb, f2_tc, f2_ea;

  logic [V-1:0]       eb;
  stmig_pkg::result_t rsp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      f2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (adv) begin
      f1_valid  <= in_valid;
      f2_valid  <= f1_valid;
      rsp_valid <= f2_valid;
    end
    if (adv) begin
      f1_item <= item;
      f1_x1   <= C'(C'(geom.spacing) * C'(quo[9:0]));
      f1_x2   <= C'(C'(geom.spacing) * C'(rem[9:0]));
      f1_ta   <= V'(item.half + quo[V-1:0]);
      f1_p    <= V'(V'(geom.m1) * V'(item.toff));

      f2_item <= f1_item;
      f2_x1   <= f1_x1;
      f2_x2   <= f1_x2;
      f2_ta   <= f1_ta;
      f2_tb   <= V'(f1_ta + V'(geom.m1) + V'(f1_item.parity));
      f2_tc   <= f1_item.parity ? V'(f1_ta + V'(1)) : V'(f1_ta + V'(geom.m1) + V'(1));
      f2_ea   <= f1_item.neg ? V'(f1_item.base - f1_p) : V'(f1_item.base + f1_p);

      rsp     <= rsp_next;
    end
  end

  assign eb = f2_item.dec ? V'(f2_ea - V'(f2_item.delta)) : V'(f2_ea + V'(f2_item.delta));

  always_comb begin
    rsp_next = '0;
    if (f2_item.bad) begin
      rsp_next.status = 1'b1;
    end else begin
      unique case (f2_item.op)
        stmig_pkg::OP_VERTEX: begin
          rsp_next.coord_one = f2_x1;
          rsp_next.coord_two = f2_x2;
        end
        stmig_pkg::OP_TRIANGLE: begin
          rsp_next.first_vertex  = f2_ta;
          rsp_next.second_vertex = f2_tb;
          rsp_next.third_vertex  = f2_tc;
        end
        stmig_pkg::OP_EDGE: begin
          rsp_next.first_vertex  = f2_ea;
          rsp_next.second_vertex = eb;
          rsp_next.side_number   = f2_item.side;
        end
        default: begin
          rsp_next.status = 1'b1;
        end
      endcase
    end
  end

endmodule

[rtl/structured_tri_mesh_index_gen.sv]
// throughput: one beat per cycle unless a stalled response holds the pipe;
// the depth is set by the 21-stage divider (one quotient bit per stage)
// plus two front and three back stages
// reset: synchronous rst clears every valid bit and loads row width 16,
// row count 16 and spacing 1.0; a stalled response holds the whole pipe
module structured_tri_mesh_index_gen (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  stmig_pkg::query_t            req,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output stmig_pkg::result_t           rsp,
  input  logic                         cfg_we,
  input  logic [stmig_pkg::CIDX_W-1:0] cfg_index,
  input  logic [stmig_pkg::CFG_W-1:0]  cfg_data
);

  localparam int D = stmig_pkg::DIM_W;

  // configuration, dimensions kept already clamped
  logic [D-1:0]                m1, m2;
  logic [stmig_pkg::SPC_W-1:0] spacing;

  // derived geometry, refreshed every cycle from the registers
  logic [stmig_pkg::IDX_W-1:0] nv, ntri, top_base, left_base;
  stmig_pkg::geom_t            geom;

  // whole pipe moves unless a finished beat sits stalled at the output
  logic adv;

  logic                        dec_valid;
  logic [stmig_pkg::IDX_W-1:0] dec_num;
  logic [D-1:0]                dec_den;
  stmig_pkg::item_t            dec_item;

  logic                        div_valid;
  logic [stmig_pkg::IDX_W-1:0] div_quo;
  logic [D-1:0]                div_rem;
  stmig_pkg::item_t            div_item;

  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1      <= D'(16);
      m2      <= D'(16);
      spacing <= 16'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stmig_pkg::REG_ROW_WIDTH: m1      <= stmig_pkg::clamp_side(cfg_data[D-1:0]);
        stmig_pkg::REG_ROW_COUNT: m2      <= stmig_pkg::clamp_side(cfg_data[D-1:0]);
        stmig_pkg::REG_SPACING:   spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // vertex count, triangle count and the two boundary bases
  always_ff @(posedge clk) begin
    nv        <= 21'(22'(m1) * 22'(m2));
    ntri      <= 21'({22'(m1 - D'(1)) * 22'(m2 - D'(1)), 1'b0});
    top_base  <= 21'(22'(m1 + D'(1)) * 22'(m2 + D'(1)) - 22'd4);
    left_base <= 21'(22'(m1) * 22'(m2 - D'(1)));
  end

  assign geom = '{m1: m1, m2: m2, spacing: spacing, nv: nv, ntri: ntri,
                  top_base: top_base, left_base: left_base};

  stmig_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req),
    .geom      (geom),
    .dec_valid (dec_valid),
    .num       (dec_num),
    .den       (dec_den),
    .item      (dec_item)
  );

  // row and column for vertices, cell row for triangles
  stmig_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (dec_valid),
    .num       (dec_num),
    .den       (dec_den),
    .in_item   (dec_item),
    .out_valid (div_valid),
    .quo       (div_quo),
    .rem       (div_rem),
    .out_item  (div_item)
  );

  stmig_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .quo       (div_quo),
    .rem       (div_rem),
    .item      (div_item),
    .geom      (geom),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // a flagged beat carries nothing else
  a_bad_is_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status |-> rsp.first_vertex == '0 && rsp.second_vertex == '0 &&
      rsp.third_vertex == '0 && rsp.coord_one == '0 && rsp.coord_two == '0 &&
      rsp.side_number == stmig_pkg::SIDE_NONE)
    else $error("flagged response carries data");

  // edge results never carry coordinates or a third vertex
  a_edge_only: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.side_number != stmig_pkg::SIDE_NONE |->
      rsp.coord_one == '0 && rsp.coord_two == '0 && rsp.third_vertex == '0)
    else $error("edge response mixes fields");

  // backpressure must reach the request side in the same cycle
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("request taken while response stalled");
`endif

endmodule

[verif/structured_tri_mesh_index_gen_test.sv]
// testbench for the structured triangle mesh index generator
`timescale 1ns / 100ps

module structured_tri_mesh_index_gen_test;

  // operation value with no meaning, must come back flagged
  localparam logic [1:0] OP_ILLEGAL = 2'd3;

  // answer book: predicts each grid query and matches responses in order
  class grid_scoreboard;
    bit [10:0] width_reg = 11'd16;
    bit [10:0] count_reg = 11'd16;
    bit [15:0] step_reg = 16'd256;
    stmig_pkg::result_t answers[$];
    int errors = 0;

    function void write_reg(logic [stmig_pkg::CIDX_W-1:0] idx,
                            logic [stmig_pkg::CFG_W-1:0] data);
      case (idx)
        stmig_pkg::REG_ROW_WIDTH: width_reg = data[10:0];
        stmig_pkg::REG_ROW_COUNT: count_reg = data[10:0];
        stmig_pkg::REG_SPACING: step_reg = data;
        default: ;
      endcase
    endfunction

    function longint unsigned side_len(bit [10:0] v);
      if (v < 2) return 2;
      if (v > stmig_pkg::MAX_SIDE) return stmig_pkg::MAX_SIDE;
      return v;
    endfunction

    // work out the grid entry for one accepted query beat
    function void note_query(stmig_pkg::query_t q);
      longint unsigned m1, m2, n, a, b, c, x1, x2, sd;
      stmig_pkg::result_t r;
      bit bad;
      m1 = side_len(width_reg);
      m2 = side_len(count_reg);
      n = q.entry_index;
      a = 0; b = 0; c = 0; x1 = 0; x2 = 0; sd = stmig_pkg::SIDE_NONE;
      bad = 0;
      case (q.operation)
        stmig_pkg::OP_VERTEX: begin
          if (n < m1 * m2) begin
            x1 = step_reg * (n / m1);
            x2 = step_reg * (n % m1);
          end else bad = 1;
        end
        stmig_pkg::OP_TRIANGLE: begin
          if (n < 2 * (m1 - 1) * (m2 - 1)) begin
            a = n / 2 + n / (2 * (m1 - 1));
            // even index: upper-left half of the cell
            if (!n[0]) begin
              b = a + m1;
              c = b + 1;
            end else begin
              b = a + m1 + 1;
              c = a + 1;
            end
          end else bad = 1;
        end
        stmig_pkg::OP_EDGE: begin
          if (n < m1 - 1) begin
            a = n; b = a + 1; sd = stmig_pkg::SIDE_BOTTOM;
          end else if (n < m1 + m2 - 2) begin
            a = m1 - 1 + m1 * (n - (m1 - 1)); b = a + m1; sd = stmig_pkg::SIDE_RIGHT;
          end else if (n < 2 * m1 + m2 - 3) begin
            a = m1 * m2 + m1 + m2 - 3 - n; b = a - 1; sd = stmig_pkg::SIDE_TOP;
          end else if (n < 2 * (m1 + m2) - 4) begin
            a = m1 * (m2 - 1) - m1 * (n - 2 * (m1 - 1) - (m2 - 1));
            b = a - m1; sd = stmig_pkg::SIDE_LEFT;
          end else bad = 1;
        end
        default: bad = 1;
      endcase
      if (bad) begin
        a = 0; b = 0; c = 0; x1 = 0; x2 = 0; sd = stmig_pkg::SIDE_NONE;
      end
      r.first_vertex = a[stmig_pkg::VTX_W-1:0];
      r.second_vertex = b[stmig_pkg::VTX_W-1:0];
      r.third_vertex = c[stmig_pkg::VTX_W-1:0];
      r.coord_one = x1[stmig_pkg::CRD_W-1:0];
      r.coord_two = x2[stmig_pkg::CRD_W-1:0];
      r.side_number = sd[stmig_pkg::SIDE_W-1:0];
      r.status = bad;
      answers.push_back(r);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(stmig_pkg::result_t r);
      stmig_pkg::result_t e;
      if (answers.size() == 0) begin
        report("unexpected beat", 1, 0);
        return;
      end
      e = answers.pop_front();
      if (r.first_vertex !== e.first_vertex) report("first_vertex", r.first_vertex, e.first_vertex);
      if (r.second_vertex !== e.second_vertex)
        report("second_vertex", r.second_vertex, e.second_vertex);
      if (r.third_vertex !== e.third_vertex) report("third_vertex", r.third_vertex, e.third_vertex);
      if (r.coord_one !== e.coord_one) report("coord_one", r.coord_one, e.coord_one);
      if (r.coord_two !== e.coord_two) report("coord_two", r.coord_two, e.coord_two);
      if (r.side_number !== e.side_number) report("side_number", r.side_number, e.side_number);
      if (r.status !== e.status) report("status", r.status, e.status);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  stmig_pkg::query_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 0;
  stmig_pkg::result_t rsp;
  logic cfg_we = 0;
  logic [stmig_pkg::CIDX_W-1:0] cfg_index = stmig_pkg::REG_ROW_WIDTH;
  logic [stmig_pkg::CFG_W-1:0] cfg_data = '0;

  grid_scoreboard book = new();
  int calm_sender = 0;   // when set, the sender never idles
  int calm_receiver = 0; // when set, the receiver never stalls
  bit hold_off = 0;      // long receiver hold-off requested
  bit sending_done = 0;

  always #4 clk = ~clk;

  structured_tri_mesh_index_gen dut (.*);

  // receiver: random stalls, one long hold-off on request
  initial begin
    int held;
    bit hold_done;
    hold_done = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        rsp_stall <= 1;
        for (held = 0; held < 120; held++) @(posedge clk);
        hold_done = 1;
      end
      rsp_stall <= (!calm_receiver && $urandom_range(99) < 33);
      @(posedge clk);
    end
  end

  // check every response beat accepted at this edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) book.check_result(rsp);
  end

  // offer one query and hold it until accepted; gaps come before the beat
  task automatic send_query(logic [1:0] op, int idx);
    while (!calm_sender && $urandom_range(99) < 33) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1;
    req.operation <= op;
    req.entry_index <= stmig_pkg::IDX_W'(idx);
    @(posedge clk);
    while (req_stall) @(posedge clk);
    book.note_query(req);
  endtask

  task automatic write_reg(logic [stmig_pkg::CIDX_W-1:0] idx,
                           logic [stmig_pkg::CFG_W-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    book.write_reg(idx, data);
  endtask

  // let the pipe drain before touching the registers
  task automatic drain;
    req_valid <= 0;
    @(posedge clk);
    while (book.answers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_grid(int w, int c, int s);
    write_reg(stmig_pkg::REG_ROW_WIDTH, stmig_pkg::CFG_W'(w));
    write_reg(stmig_pkg::REG_ROW_COUNT, stmig_pkg::CFG_W'(c));
    write_reg(stmig_pkg::REG_SPACING, stmig_pkg::CFG_W'(s));
  endtask

  // random query: mostly in range for the current grid, sometimes out
  task automatic random_query;
    int m1, m2, lim, pick;
    logic [1:0] op;
    int idx;
    m1 = int'(book.side_len(book.width_reg));
    m2 = int'(book.side_len(book.count_reg));
    pick = $urandom_range(99);
    op = (pick < 3) ? OP_ILLEGAL : 2'($urandom_range(2));
    case (op)
      stmig_pkg::OP_VERTEX: lim = m1 * m2;
      stmig_pkg::OP_TRIANGLE: lim = 2 * (m1 - 1) * (m2 - 1);
      default: lim = 2 * (m1 + m2) - 4;
    endcase
    pick = $urandom_range(99);
    if (pick < 8) idx = int'($urandom_range(2097151));
    else if (pick < 14) idx = lim - 1 + int'($urandom_range(1));
    else idx = int'($urandom_range(lim - 1));
    send_query(op, idx);
  endtask

  initial begin
    int phase, k;
    int widths[6] = '{16, 2, 1024, 0, 2047, 37};
    int counts[6] = '{16, 1024, 2, 1, 1500, 53};
    int steps[6] = '{256, 65535, 0, 1, 43210, 777};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset grid 16 x 16, each side and each limit
    send_query(stmig_pkg::OP_VERTEX, 0);
    send_query(stmig_pkg::OP_VERTEX, 255);
    send_query(stmig_pkg::OP_VERTEX, 256);
    send_query(stmig_pkg::OP_TRIANGLE, 0);
    send_query(stmig_pkg::OP_TRIANGLE, 1);
    send_query(stmig_pkg::OP_TRIANGLE, 449);
    send_query(stmig_pkg::OP_TRIANGLE, 450);
    send_query(stmig_pkg::OP_EDGE, 0);
    send_query(stmig_pkg::OP_EDGE, 14);
    send_query(stmig_pkg::OP_EDGE, 15);
    send_query(stmig_pkg::OP_EDGE, 29);
    send_query(stmig_pkg::OP_EDGE, 30);
    send_query(stmig_pkg::OP_EDGE, 44);
    send_query(stmig_pkg::OP_EDGE, 45);
    send_query(stmig_pkg::OP_EDGE, 59);
    send_query(stmig_pkg::OP_EDGE, 60);
    send_query(OP_ILLEGAL, 5);
    send_query(stmig_pkg::OP_VERTEX, 2097151);
    send_query(stmig_pkg::OP_TRIANGLE, 2097151);
    drain();
    set_grid(1024, 1024, 65535);
    send_query(stmig_pkg::OP_VERTEX, 1048575);
    send_query(stmig_pkg::OP_TRIANGLE, 2093057);
    send_query(stmig_pkg::OP_EDGE, 4091);
    send_query(stmig_pkg::OP_EDGE, 4092);

    // random phases across several grid settings
    for (phase = 0; phase < 6; phase++) begin
      drain();
      set_grid(widths[phase], counts[phase], steps[phase]);
      calm_sender = (phase == 2);
      calm_receiver = (phase == 4);
      if (phase == 1) begin
        calm_sender = 1;
        hold_off = 1;
      end
      for (k = 0; k < 320; k++) random_query();
    end
    req_valid <= 0;
    sending_done = 1;
  end

  // end of run
  initial begin
    int waited;
    wait (sending_done);
    waited = 0;
    while (book.answers.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (book.errors == 0 && book.answers.size() == 0)
      $display("PASS structured_tri_mesh_index_gen");
    else
      $display("FAIL structured_tri_mesh_index_gen");
    $finish;
  end

  // hard limit
  initial begin
    #2000000;
    $display("FAIL structured_tri_mesh_index_gen");
    $finish;
  end

endmodule
